/* hdl/segmented_focus_sharpness_top_assert.svh */
// Assertion helpers shared by the focus sharpness modules.
// Both expect clk and arst_n in scope.
`ifndef SEGMENTED_FOCUS_SHARPNESS_TOP_ASSERT_SVH
`define SEGMENTED_FOCUS_SHARPNESS_TOP_ASSERT_SVH

// same-cycle implication
`define SFS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sfs assertion failed (same cycle)");

// next-cycle implication
`define SFS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sfs assertion failed (next cycle)");

`endif

/* hdl/sfs_pkg.sv */
`default_nettype none

package sfs_pkg;

	localparam int SAMPLE_W = 16;
	localparam int CH_W = 15;
	localparam int CHANNELS = 3;
	localparam int SQ_W = 2 * CH_W;
	localparam int SUM_W = 42;
	localparam int SEG_IDX_W = 3;
	localparam int FIRST_W = 13;
	localparam int LEN_W = 10;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_INDEX_W = 1;

	localparam int DEF_SEGMENTS = 8;
	localparam int DEF_MAX_LINE_PIXELS = 8192;

	localparam logic [FIRST_W-1:0] FIRST_RESET = 13'd0;
	localparam logic [LEN_W-1:0] LEN_RESET = 10'd512;

	localparam logic [CFG_INDEX_W-1:0] REG_FIRST_PIXEL = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SEGMENT_LENGTH = 1'd1;

	typedef struct packed {
		logic [SAMPLE_W-1:0] red_sample;
		logic [SAMPLE_W-1:0] green_sample;
		logic [SAMPLE_W-1:0] blue_sample;
		logic line_end;
	} pixel_t;

	typedef struct packed {
		logic [SEG_IDX_W-1:0] segment_index;
		logic [SUM_W-1:0] sharpness;
		logic last_segment;
	} result_t;

	// halved pixel, channel 0 is red
	typedef struct packed {
		logic [CHANNELS-1:0][CH_W-1:0] ch;
		logic line_end;
	} halved_t;

	// squared gradients plus segment bookkeeping for the accumulator
	typedef struct packed {
		logic [CHANNELS-1:0][SQ_W-1:0] sq;
		logic add;
		logic emit;
		logic line_end;
		logic [SEG_IDX_W-1:0] idx;
		logic last;
	} grad_t;

endpackage

`default_nettype wire

/* hdl/sfs_stream_if.sv */
`default_nettype none

interface sfs_stream_if #(
	parameter type payload_t = logic
);
	logic valid;
	logic ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

`default_nettype wire

/* hdl/sfs_grad.sv */
`default_nettype none
`include "segmented_focus_sharpness_top_assert.svh"

module sfs_grad #(
	parameter int SEGMENTS = sfs_pkg::DEF_SEGMENTS,
	parameter int MAX_LINE_PIXELS = sfs_pkg::DEF_MAX_LINE_PIXELS
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [sfs_pkg::FIRST_W-1:0] first_pixel,
	input wire logic [sfs_pkg::LEN_W-1:0] segment_length,
	input wire logic s1_valid,
	input wire sfs_pkg::halved_t s1,
	output logic s1_go,
	input wire logic s2_go,
	output logic s2_valid,
	output sfs_pkg::grad_t s2
);

	localparam int PosW = $clog2(MAX_LINE_PIXELS);
	localparam int SegW = $clog2(SEGMENTS + 1);
	localparam int FirstW = sfs_pkg::FIRST_W;
	localparam int CmpW = (PosW > FirstW) ? PosW : FirstW;
	localparam int LenW = sfs_pkg::LEN_W;
	localparam int ChW = sfs_pkg::CH_W;
	localparam int SqW = sfs_pkg::SQ_W;
	localparam int Chans = sfs_pkg::CHANNELS;
	localparam int IdxW = sfs_pkg::SEG_IDX_W;

	logic [PosW-1:0] pos_q;
	logic [SegW-1:0] seg_q;
	logic [LenW-1:0] off_q;
	logic [Chans-1:0][ChW-1:0] e0_q, e1_q;
	logic s2_valid_q;
	sfs_pkg::grad_t s2_q;

	logic in_seg, do_add, do_emit;
	logic [LenW-1:0] seg_end;
	logic [Chans-1:0][ChW-1:0] diff;
	logic [Chans-1:0][SqW-1:0] sq;

	assign s1_go = s1_valid && (!s2_valid_q || s2_go);
	assign s2_valid = s2_valid_q;
	assign s2 = s2_q;

	always_comb begin
		in_seg = (CmpW'(pos_q) >= CmpW'(first_pixel)) && (seg_q < SegW'(SEGMENTS));
		seg_end = segment_length - LenW'(1);
		do_add = in_seg && (off_q >= LenW'(2));
		do_emit = in_seg && (off_q == seg_end);
		for (int c = 0; c < Chans; c++) begin
			diff[c] = (s1.ch[c] >= e1_q[c]) ? (s1.ch[c] - e1_q[c]) : (e1_q[c] - s1.ch[c]);
			sq[c] = SqW'(diff[c]) * SqW'(diff[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			seg_q <= '0;
			off_q <= '0;
			e0_q <= '0;
			e1_q <= '0;
			s2_valid_q <= 1'b0;
		end else begin
			if (s2_go)
				s2_valid_q <= 1'b0;
			if (s1_go) begin
				s2_valid_q <= 1'b1;
				if (in_seg) begin
					if (do_emit) begin
						seg_q <= seg_q + SegW'(1);
						off_q <= '0;
					end else begin
						off_q <= off_q + LenW'(1);
					end
				end
				e1_q <= e0_q;
				e0_q <= s1.ch;
				if (pos_q < PosW'(MAX_LINE_PIXELS - 1))
					pos_q <= pos_q + PosW'(1);
				if (s1.line_end) begin
					pos_q <= '0;
					seg_q <= '0;
					off_q <= '0;
					e0_q <= '0;
					e1_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			s2_q.sq <= sq;
			s2_q.add <= do_add;
			s2_q.emit <= do_emit;
			s2_q.line_end <= s1.line_end;
			s2_q.idx <= IdxW'(seg_q);
			s2_q.last <= (seg_q == SegW'(SEGMENTS - 1));
		end
	end

	`SFS_ASSERT_NOW(a_seg_bound, 1'b1, seg_q <= SegW'(SEGMENTS))
	`SFS_ASSERT_NEXT(a_line_clear, s1_go && s1.line_end,
		pos_q == '0 && seg_q == '0 && off_q == '0)

endmodule

`default_nettype wire

/* hdl/sfs_accum.sv */
`default_nettype none
`include "segmented_focus_sharpness_top_assert.svh"

module sfs_accum (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s2_valid,
	input wire sfs_pkg::grad_t s2,
	output logic s2_go,
	sfs_stream_if.source result
);

	localparam int SumW = sfs_pkg::SUM_W;
	localparam int SqW = sfs_pkg::SQ_W;
	localparam int AddW = SqW + 2;

	logic [SumW-1:0] sum_q;
	logic out_valid_q;
	sfs_pkg::result_t out_q;

	logic [AddW-1:0] add_val;
	logic [SumW-1:0] total;

	assign result.valid = out_valid_q;
	assign result.payload = out_q;

	// an emitting item needs the output register free; others pass freely
	assign s2_go = s2_valid && (!s2.emit || !out_valid_q || result.ready);

	always_comb begin
		add_val = AddW'(s2.sq[0]) + AddW'(s2.sq[1]) + AddW'(s2.sq[2]);
		total = sum_q + (s2.add ? SumW'(add_val) : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (result.valid && result.ready)
				out_valid_q <= 1'b0;
			if (s2_go) begin
				if (s2.emit) begin
					out_valid_q <= 1'b1;
					sum_q <= '0;
				end else begin
					sum_q <= total;
				end
				if (s2.line_end)
					sum_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go && s2.emit) begin
			out_q.segment_index <= s2.idx;
			out_q.sharpness <= total;
			out_q.last_segment <= s2.last;
		end
	end

	`SFS_ASSERT_NEXT(a_sum_clear_emit, s2_go && s2.emit, sum_q == '0)
	`SFS_ASSERT_NEXT(a_sum_clear_line, s2_go && s2.line_end, sum_q == '0)

endmodule

`default_nettype wire

/* hdl/segmented_focus_sharpness_top.sv */
// Segmented focus sharpness measure for a line-scan RGB sensor.
// pixel channel: one RGB pixel per transfer (three 16-bit samples and a
// line_end flag). result channel: one transfer per finished segment with
// its index, the 42-bit sum of squared two-apart gradients and a flag on
// the last segment. The user must write configuration (first_pixel,
// segment_length) through cfg_we/cfg_index/cfg_data only while the
// block is idle; the block itself does not enforce this. Throughput: one
// pixel per cycle while no segment-ending pixel waits for the output
// register. An accepted pixel passes through the input register, then
// the square stage, then the accumulator and output register.
// The output register decouples the channels: while a result waits, pixels
// that end no segment keep flowing; a segment-ending pixel waits in the
// square stage until the output register is free, and the input stalls
// behind it.
// Reset clears the line position, segment counters, pixel history and the
// running sum, and sets first_pixel to 0 and segment_length to 512.
`default_nettype none

module segmented_focus_sharpness_top #(
	parameter int SEGMENTS = sfs_pkg::DEF_SEGMENTS,
	parameter int MAX_LINE_PIXELS = sfs_pkg::DEF_MAX_LINE_PIXELS
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [sfs_pkg::CFG_INDEX_W-1:0] cfg_index,
	input wire logic [sfs_pkg::CFG_DATA_W-1:0] cfg_data,
	sfs_stream_if.sink pixel,
	sfs_stream_if.source result
);

	localparam int ChW = sfs_pkg::CH_W;
	localparam int LenW = sfs_pkg::LEN_W;
	localparam int FirstW = sfs_pkg::FIRST_W;

	logic [FirstW-1:0] first_q;
	logic [LenW-1:0] len_q;

	logic s1_valid_q;
	sfs_pkg::halved_t s1_q;
	sfs_pkg::pixel_t pix;
	logic s1_go, s2_go, s2_valid;
	sfs_pkg::grad_t s2;
	logic accept;

	assign pix = pixel.payload;
	assign pixel.ready = !s1_valid_q || s1_go;
	assign accept = pixel.valid && pixel.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= sfs_pkg::FIRST_RESET;
			len_q <= sfs_pkg::LEN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sfs_pkg::REG_FIRST_PIXEL: first_q <= FirstW'(cfg_data);
				sfs_pkg::REG_SEGMENT_LENGTH: len_q <= LenW'(cfg_data);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (accept)
			s1_valid_q <= 1'b1;
		else if (s1_go)
			s1_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_q.ch[0] <= ChW'(pix.red_sample >> 1);
			s1_q.ch[1] <= ChW'(pix.green_sample >> 1);
			s1_q.ch[2] <= ChW'(pix.blue_sample >> 1);
			s1_q.line_end <= pix.line_end;
		end
	end

	sfs_grad #(
		.SEGMENTS(SEGMENTS),
		.MAX_LINE_PIXELS(MAX_LINE_PIXELS)
	) u_grad (
		.clk(clk),
		.arst_n(arst_n),
		.first_pixel(first_q),
		.segment_length(len_q),
		.s1_valid(s1_valid_q),
		.s1(s1_q),
		.s1_go(s1_go),
		.s2_go(s2_go),
		.s2_valid(s2_valid),
		.s2(s2)
	);

	sfs_accum u_accum (
		.clk(clk),
		.arst_n(arst_n),
		.s2_valid(s2_valid),
		.s2(s2),
		.s2_go(s2_go),
		.result(result)
	);

endmodule

`default_nettype wire
